[rtl/iee_pkg.sv]
// Package for the infix expression evaluator: operator codes, status codes,
// transaction payloads, controller command and status structs. No dependencies.
`timescale 1ns / 1ps
package iee_pkg;

  localparam int StackDepthDefault = 16;
  localparam int DataWidth = 32;
  localparam int SymWidth = 8;

  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIVZERO   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChMul    = 8'h2A;
  localparam logic [7:0] ChAdd    = 8'h2B;
  localparam logic [7:0] ChSub    = 8'h2D;
  localparam logic [7:0] ChDiv    = 8'h2F;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Input and result transaction payloads
  typedef struct packed {
    logic [SymWidth-1:0] symbol;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic [1:0]           status;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic push_num;     // push digit operand
    logic push_op;      // push operator in op_code
    logic pop_op;       // drop top operator
    logic load_top;     // register top-of-stack reads
    logic start_arith;  // begin a reduction on the registered operands
    logic finish_arith; // write arithmetic result, pop one operand
    logic clear;        // empty stacks and error
    logic [1:0] err;    // error to raise (ST_OK: none)
    op_t  op_code;
    logic [3:0] digit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_empty;
    logic op_full;
    logic num_full;
    logic num_lt2;
    logic num_one;
    logic num_empty;
    logic arith_done;
    op_t  op_top;       // registered read of the operator stack top
  } stat_t;

  function automatic logic [1:0] prec(input op_t op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    else if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    return p;
  endfunction

endpackage

[rtl/iee_stream_if.sv]
// Valid/ready stream interface with a parameterised payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface iee_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/iee_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module iee_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/iee_divider.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on nothing.
`timescale 1ns / 1ps
module iee_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[31]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        q    <= num[31] ? (32'd0 - num) : num;
        d    <= den[31] ? (32'd0 - den) : den;
        neg  <= num[31] ^ den[31];
      end else if (busy) begin
        // shift one bit, subtract where it fits
        if (!trial[32]) begin
          rem <= trial[31:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? (32'd0 - q) : q;
endmodule

[rtl/iee_datapath.sv]
// Datapath: operand and operator stacks, arithmetic unit, error register.
// Depends on iee_pkg, iee_ram and iee_divider.
`timescale 1ns / 1ps
module iee_datapath #(
  parameter int StackDepth = iee_pkg::StackDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  iee_pkg::cmd_t         cmd,
  output iee_pkg::stat_t        stat,
  output logic [31:0]           value,
  output logic [1:0]            status
);
  localparam int AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int CW = $clog2(StackDepth + 1);
  localparam logic [CW-1:0] Full = CW'(StackDepth);

  logic [CW-1:0] num_cnt;
  logic [CW-1:0] op_cnt;
  logic [1:0]    err;
  logic [31:0]   rhs_q;
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;
  logic [2:0]    op_rd;
  logic [31:0]   lhs_q;
  logic [31:0]   res;
  logic          div_done;
  logic [31:0]   quo;
  logic          arith_done;
  logic          is_div;
  logic          div_start;
  logic          num_we;
  logic [AW-1:0] num_waddr;
  logic [31:0]   num_wdata;
  logic [AW-1:0] ra_a;
  logic [AW-1:0] ra_b;
  iee_pkg::op_t  cur_op;
  logic          wait_div;

  // stack read addresses: top and the one under it
  assign ra_a = AW'(num_cnt - CW'(1));
  assign ra_b = AW'(num_cnt - CW'(2));

  assign num_we    = cmd.push_num || cmd.finish_arith;
  assign num_waddr = cmd.push_num ? AW'(num_cnt) : AW'(num_cnt - CW'(2));
  assign num_wdata = cmd.push_num ? {28'd0, cmd.digit} : res;

  iee_ram #(.Width(32), .Depth(StackDepth)) u_num_a (
    .clk, .we(num_we), .waddr(num_waddr), .wdata(num_wdata), .raddr(ra_a), .rdata(rd_a));
  iee_ram #(.Width(32), .Depth(StackDepth)) u_num_b (
    .clk, .we(num_we), .waddr(num_waddr), .wdata(num_wdata), .raddr(ra_b), .rdata(rd_b));
  iee_ram #(.Width(3), .Depth(StackDepth)) u_ops (
    .clk, .we(cmd.push_op), .waddr(AW'(op_cnt)), .wdata(cmd.op_code),
    .raddr(AW'(op_cnt - CW'(1))), .rdata(op_rd));

  assign div_start = cmd.start_arith && (cmd.op_code == iee_pkg::OP_DIV) && (rhs_q != 32'd0);
  iee_divider u_div (
    .clk, .rst, .start(div_start), .num(lhs_q), .den(rhs_q), .done(div_done), .quo(quo));

  // compute result of the current operator
  always_comb begin
    case (cur_op)
      iee_pkg::OP_ADD: res = lhs_q + rhs_q;
      iee_pkg::OP_SUB: res = lhs_q - rhs_q;
      iee_pkg::OP_MUL: res = lhs_q * rhs_q;
      iee_pkg::OP_DIV: res = is_div ? quo : 32'd0;
      default:         res = 32'd0;
    endcase
  end

  // hold operands and track arithmetic progress
  always_ff @(posedge clk) begin
    if (rst) begin
      arith_done <= 1'b0;
      wait_div   <= 1'b0;
    end else begin
      arith_done <= 1'b0;
      if (cmd.load_top) begin
        rhs_q <= rd_a;
        lhs_q <= rd_b;
      end
      if (cmd.start_arith) begin
        cur_op <= cmd.op_code;
        is_div <= div_start;
        if (div_start) begin
          wait_div <= 1'b1;
        end else begin
          arith_done <= 1'b1;
        end
      end
      if (wait_div && div_done) begin
        wait_div   <= 1'b0;
        arith_done <= 1'b1;
      end
    end
  end

  // counters and sticky error
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      num_cnt <= '0;
      op_cnt  <= '0;
      err     <= iee_pkg::ST_OK;
    end else begin
      if (cmd.push_num) num_cnt <= num_cnt + CW'(1);
      if (cmd.finish_arith) num_cnt <= num_cnt - CW'(1);
      if (cmd.push_op) op_cnt <= op_cnt + CW'(1);
      if (cmd.pop_op) op_cnt <= op_cnt - CW'(1);
      if (err == iee_pkg::ST_OK) begin
        if (cmd.err != iee_pkg::ST_OK) err <= cmd.err;
        else if (cmd.start_arith && cmd.op_code == iee_pkg::OP_DIV && rhs_q == 32'd0)
          err <= iee_pkg::ST_DIVZERO;
      end
    end
  end

  assign stat.op_empty   = (op_cnt == '0);
  assign stat.op_full    = (op_cnt >= Full);
  assign stat.num_full   = (num_cnt >= Full);
  assign stat.num_lt2    = (num_cnt < CW'(2));
  assign stat.num_one    = (num_cnt == CW'(1));
  assign stat.num_empty  = (num_cnt == '0);
  assign stat.arith_done = arith_done;
  assign stat.op_top     = iee_pkg::op_t'(op_rd);

  assign value  = rd_a;
  assign status = err;
endmodule

[rtl/iee_ctrl.sv]
// Controller state machine: decodes symbols, sequences reductions and result.
// Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     symbol,
  input  logic           last,
  output iee_pkg::cmd_t  cmd,
  input  iee_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           cap_result
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TOP   = 9'b000000010, // read top operator
    S_DEC   = 9'b000000100, // decide on the top operator
    S_OPND  = 9'b000001000, // read top operands
    S_ARITH = 9'b000010000, // start arithmetic
    S_WAIT  = 9'b000100000, // wait for result
    S_FIN   = 9'b001000000, // check count, read value
    S_CAP   = 9'b010000000, // capture value
    S_OUT   = 9'b100000000  // present the result
  } state_t;

  typedef enum logic [1:0] {
    M_OPER  = 2'd0, // reduce before pushing an operator
    M_CLOSE = 2'd1, // reduce down to '('
    M_END   = 2'd2  // reduce everything
  } mode_t;

  state_t        state;
  state_t        state_next;
  mode_t         mode;
  iee_pkg::op_t  pend_op;
  iee_pkg::op_t  red_op;
  logic          pend_last;
  logic          is_op;
  iee_pkg::op_t  dec_op;
  logic          settle;

  // decode operator characters
  always_comb begin
    is_op  = 1'b1;
    dec_op = iee_pkg::OP_ADD;
    case (symbol)
      iee_pkg::ChAdd: dec_op = iee_pkg::OP_ADD;
      iee_pkg::ChSub: dec_op = iee_pkg::OP_SUB;
      iee_pkg::ChMul: dec_op = iee_pkg::OP_MUL;
      iee_pkg::ChDiv: dec_op = iee_pkg::OP_DIV;
      default:        is_op  = 1'b0;
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cap_result = (state == S_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      pend_last <= last;
      pend_op   <= dec_op;
      if (symbol == iee_pkg::ChRparen) mode <= M_CLOSE;
      else if (is_op) mode <= M_OPER;
      else mode <= M_END;
    end
    if (state == S_DEC) red_op <= stat.op_top;
    if (state == S_FIN && pend_last) mode <= M_END;
    // once the character is settled, a last one goes on to reduce everything
    if (settle && pend_last) mode <= M_END;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.op_code = red_op;
    settle = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (symbol >= iee_pkg::ChZero && symbol <= iee_pkg::ChNine) begin
            if (stat.num_full) cmd.err = iee_pkg::ST_OVERFLOW;
            else begin
              cmd.push_num = 1'b1;
              cmd.digit = 4'(symbol - iee_pkg::ChZero);
            end
            state_next = last ? S_TOP : S_IDLE;
          end else if (symbol == iee_pkg::ChLparen) begin
            if (stat.op_full) cmd.err = iee_pkg::ST_OVERFLOW;
            else begin
              cmd.push_op = 1'b1;
              cmd.op_code = iee_pkg::OP_LPAREN;
            end
            state_next = last ? S_TOP : S_IDLE;
          end else if (symbol == iee_pkg::ChRparen || is_op || last) begin
            state_next = S_TOP;
          end
        end
      end
      S_TOP: state_next = S_DEC;
      S_DEC: begin
        if (stat.op_empty) begin
          case (mode)
            M_OPER: begin
              if (stat.op_full) cmd.err = iee_pkg::ST_OVERFLOW;
              else begin
                cmd.push_op = 1'b1;
                cmd.op_code = pend_op;
              end
              settle = 1'b1;
              state_next = pend_last ? S_TOP : S_IDLE;
            end
            M_CLOSE: begin
              cmd.err = iee_pkg::ST_MALFORMED;
              settle = 1'b1;
              state_next = pend_last ? S_TOP : S_IDLE;
            end
            default: state_next = S_FIN;
          endcase
        end else if (stat.op_top == iee_pkg::OP_LPAREN) begin
          case (mode)
            M_OPER: begin
              if (stat.op_full) cmd.err = iee_pkg::ST_OVERFLOW;
              else begin
                cmd.push_op = 1'b1;
                cmd.op_code = pend_op;
              end
              settle = 1'b1;
              state_next = pend_last ? S_TOP : S_IDLE;
            end
            M_CLOSE: begin
              cmd.pop_op = 1'b1;
              settle = 1'b1;
              state_next = pend_last ? S_TOP : S_IDLE;
            end
            default: begin
              cmd.err = iee_pkg::ST_MALFORMED;
              cmd.pop_op = 1'b1;
              state_next = S_TOP;
            end
          endcase
        end else if (mode == M_OPER &&
                     iee_pkg::prec(stat.op_top) < iee_pkg::prec(pend_op)) begin
          if (stat.op_full) cmd.err = iee_pkg::ST_OVERFLOW;
          else begin
            cmd.push_op = 1'b1;
            cmd.op_code = pend_op;
          end
          settle = 1'b1;
          state_next = pend_last ? S_TOP : S_IDLE;
        end else begin
          // reduce once
          cmd.pop_op = 1'b1;
          if (stat.num_lt2) begin
            cmd.err = iee_pkg::ST_MALFORMED;
            state_next = S_TOP;
          end else begin
            state_next = S_OPND;
          end
        end
      end
      S_OPND: begin
        cmd.load_top = 1'b1;
        state_next = S_ARITH;
      end
      S_ARITH: begin
        cmd.start_arith = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.arith_done) begin
          cmd.finish_arith = 1'b1;
          state_next = S_TOP;
        end
      end
      S_FIN: begin
        if (!stat.num_one) cmd.err = iee_pkg::ST_MALFORMED;
        state_next = S_CAP;
      end
      S_CAP: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[rtl/infix_expression_evaluator.sv]
// Infix expression evaluator: one character per input transaction.
// Digits, '(' and ignored characters are handled in the idle state; operators and ')'
// reduce stacked operators as precedence and parentheses require, a division using the shift/subtract divider.
// The last character then reduces what remains before the result transaction,
// which holds until taken; no input is accepted meanwhile.
// Synchronous active-high reset empties both stacks and clears the error.
`timescale 1ns / 1ps
module infix_expression_evaluator #(
  parameter int StackDepth = iee_pkg::StackDepthDefault
) (
  input logic   clk,
  input logic   rst,
  iee_stream_if.sink   in_ch,
  iee_stream_if.source out_ch
);
  iee_pkg::cmd_t  cmd;
  iee_pkg::stat_t stat;
  logic [31:0]    dp_value;
  logic [1:0]     dp_status;
  logic           cap_result;
  logic [31:0]    value;
  logic [1:0]     status;

  iee_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .symbol(in_ch.data.symbol), .last(in_ch.data.last),
    .cmd, .stat,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cap_result);

  iee_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk, .rst, .cmd, .stat, .value(dp_value), .status(dp_status));

  // capture result; empty stack reads as zero
  always_ff @(posedge clk) begin
    if (cap_result) begin
      value  <= stat.num_empty ? 32'd0 : dp_value;
      status <= dp_status;
    end
  end

  assign out_ch.data.value  = value;
  assign out_ch.data.status = status;
endmodule

[dv/testbench.sv]
// Testbench for the infix expression evaluator: random and directed expressions,
// checked against a behavioural predictor held in a scoreboard class.
// Depends on rtl/iee_pkg.sv, rtl/iee_stream_if.sv and the evaluator RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int Depth = iee_pkg::StackDepthDefault;
  localparam int CycleLimit = 2000000;
  localparam int ItemTarget = 850;

  // Predict expression results and compare them with the block's transactions
  class expr_scoreboard;
    logic [31:0]              operands[Depth];
    iee_pkg::op_t             operators[Depth];
    int                       n_operands;
    int                       n_operators;
    iee_pkg::status_t         err;
    iee_pkg::out_item_t       pending[$];
    int                       mismatches;

    function void clear_state();
      n_operands = 0;
      n_operators = 0;
      err = iee_pkg::ST_OK;
    endfunction

    function void flag(iee_pkg::status_t code);
      if (err == iee_pkg::ST_OK) err = code;
    endfunction

    function int rank(iee_pkg::op_t op);
      if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
      if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
      return 0;
    endfunction

    function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      if (b == 0) begin
        flag(iee_pkg::ST_DIVZERO);
        return 0;
      end
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void reduce_top();
      iee_pkg::op_t op;
      logic [31:0] lhs, rhs, res;
      if (n_operators == 0) return;
      n_operators--;
      op = operators[n_operators];
      if (op == iee_pkg::OP_LPAREN) return;
      if (n_operands < 2) begin
        flag(iee_pkg::ST_MALFORMED);
        return;
      end
      rhs = operands[n_operands-1];
      lhs = operands[n_operands-2];
      case (op)
        iee_pkg::OP_ADD: res = lhs + rhs;
        iee_pkg::OP_SUB: res = lhs - rhs;
        iee_pkg::OP_MUL: res = lhs * rhs;
        default: res = quotient(lhs, rhs);
      endcase
      n_operands--;
      operands[n_operands-1] = res;
    endfunction

    function void push_op(iee_pkg::op_t op);
      if (n_operators >= Depth) begin
        flag(iee_pkg::ST_OVERFLOW);
        return;
      end
      operators[n_operators] = op;
      n_operators++;
    endfunction

    function void apply_op(iee_pkg::op_t op);
      while (n_operators > 0 && operators[n_operators-1] != iee_pkg::OP_LPAREN &&
             rank(operators[n_operators-1]) >= rank(op))
        reduce_top();
      push_op(op);
    endfunction

    // Note an accepted input transaction and queue any result it causes
    function void note_input(iee_pkg::in_item_t it);
      iee_pkg::out_item_t r;
      if (it.symbol >= iee_pkg::ChZero && it.symbol <= iee_pkg::ChNine) begin
        if (n_operands >= Depth) flag(iee_pkg::ST_OVERFLOW);
        else begin
          operands[n_operands] = 32'(it.symbol - iee_pkg::ChZero);
          n_operands++;
        end
      end else begin
        case (it.symbol)
          iee_pkg::ChLparen: push_op(iee_pkg::OP_LPAREN);
          iee_pkg::ChRparen: begin
            while (n_operators > 0 && operators[n_operators-1] != iee_pkg::OP_LPAREN)
              reduce_top();
            if (n_operators == 0) flag(iee_pkg::ST_MALFORMED);
            else n_operators--;
          end
          iee_pkg::ChAdd: apply_op(iee_pkg::OP_ADD);
          iee_pkg::ChSub: apply_op(iee_pkg::OP_SUB);
          iee_pkg::ChMul: apply_op(iee_pkg::OP_MUL);
          iee_pkg::ChDiv: apply_op(iee_pkg::OP_DIV);
          default: ;
        endcase
      end
      if (!it.last) return;
      while (n_operators > 0) begin
        if (operators[n_operators-1] == iee_pkg::OP_LPAREN) flag(iee_pkg::ST_MALFORMED);
        reduce_top();
      end
      if (n_operands != 1) flag(iee_pkg::ST_MALFORMED);
      r.value = (n_operands > 0) ? operands[n_operands-1] : 32'd0;
      r.status = err;
      pending.push_back(r);
      clear_state();
    endfunction

    // Check one result transaction against the oldest expectation
    function void check_result(iee_pkg::out_item_t got);
      iee_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d status=%0d",
                                       $signed(got.value), got.status);
        return;
      end
      want = pending.pop_front();
      if (want.value !== got.value || want.status !== got.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                   $signed(want.value), want.status, $signed(got.value), got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  iee_stream_if #(.payload_t(iee_pkg::in_item_t))  in_ch ();
  iee_stream_if #(.payload_t(iee_pkg::out_item_t)) out_ch ();

  infix_expression_evaluator u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  expr_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int cycles = 0;
  int items_sent = 0;
  iee_pkg::in_item_t seq[$];

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Check results on accepted transactions
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.data);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one transaction, with random idle cycles before it; valid stays up
  task automatic send_item(iee_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  // Drop valid once the sender stops
  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  // Send a string as one expression, the final character marked last
  task automatic send_text(string s);
    iee_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.symbol = s[i];
      it.last = (i == s.len() - 1);
      send_item(it);
    end
  endtask

  function automatic logic [7:0] rand_digit();
    return iee_pkg::ChZero + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(3))
      0: return iee_pkg::ChAdd;
      1: return iee_pkg::ChSub;
      2: return iee_pkg::ChMul;
      default: return iee_pkg::ChDiv;
    endcase
  endfunction

  // Build a well-formed expression into seq
  function automatic void build_expr(int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) seq.push_back('{rand_op(), 1'b0});
      if (depth < 3 && $urandom_range(3) == 0) begin
        seq.push_back('{iee_pkg::ChLparen, 1'b0});
        build_expr(depth + 1);
        seq.push_back('{iee_pkg::ChRparen, 1'b0});
      end else seq.push_back('{rand_digit(), 1'b0});
    end
  endfunction

  // Random expression: mostly well formed, some noise and broken ones
  task automatic send_random_expr();
    int kind;
    seq.delete();
    kind = $urandom_range(99);
    if (kind < 75) begin
      build_expr(0);
      if ($urandom_range(4) == 0) seq.insert($urandom_range(seq.size()),
                                             '{8'($urandom_range(255)), 1'b0});
    end else begin
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(5))
          0: seq.push_back('{8'($urandom_range(255)), 1'b0});
          1: seq.push_back('{iee_pkg::ChLparen, 1'b0});
          2: seq.push_back('{iee_pkg::ChRparen, 1'b0});
          3: seq.push_back('{rand_op(), 1'b0});
          default: seq.push_back('{rand_digit(), 1'b0});
        endcase
      end
    end
    seq[seq.size()-1].last = 1'b1;
    foreach (seq[i]) send_item(seq[i]);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    sb.mismatches = 0;
    sb.clear_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed expressions
    send_text("1+2*3");
    send_text("(1+2)*3");
    send_text("8-3-2");
    send_text("9/0+1");
    send_text("0-7/2");
    send_text("1)");
    send_text("(2+3");
    send_text("+");
    send_text("12");
    send_text("a 5x");
    send_text("9*9*9*9*9*9*9*9*9*9*9/1");
    send_text("0-8*8*8*8*8*8*8*8*8*8*8/(0-1)");
    send_text("11111111111111111");
    send_text("(((((((((((((((((1");
    send_item('{8'hFF, 1'b1});
    stop_input();
    drain();

    // Pressure: long receiver hold-off while expressions keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (6) send_random_expr();
        stop_input();
      end
    join
    drain();

    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (10) begin
        if (items_sent < ItemTarget) send_random_expr();
      end
      phase++;
    end
    stop_input();

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
